// File: rtl/core/bcdec_pkg.sv
// Shared types and constants for the BC1/BC3 texture block decoder.
// No dependencies; imported by every module of the decoder.
package bcdec_pkg;

	localparam int CfgIdxW  = 2;
	localparam int CfgDataW = 15;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_FORMAT_MODE  = 2'd0,
		CFG_IMAGE_WIDTH  = 2'd1,
		CFG_IMAGE_HEIGHT = 2'd2
	} cfg_reg_t;

	// Constant reciprocals: floor(x * R >> S) equals floor(x / d) over the sums that occur.
	localparam logic [9:0]  RECIP3 = 10'd683;
	localparam int          SHIFT3 = 11;
	localparam logic [11:0] RECIP5 = 12'd3277;
	localparam logic [11:0] RECIP7 = 12'd2341;
	localparam int          SHIFT57 = 14;

	typedef enum logic [1:0] {
		DIV_ONE   = 2'd0,
		DIV_TWO   = 2'd1,
		DIV_THREE = 2'd2
	} cdiv_t;

	// Per-block header produced by the position tracker.
	typedef struct packed {
		logic        bc3;
		logic [11:0] col;
		logic [11:0] row;
		logic [1:0]  ncols_m1;
		logic [1:0]  nrows_m1;
		logic        nonempty;
		logic        last_img;
	} blk_info_t;

	// Block held in the first stage while its texels are emitted.
	typedef struct packed {
		logic [63:0] alpha_word;
		logic [63:0] color_word;
		logic        bc3;
		logic [11:0] col;
		logic [11:0] row;
		logic [1:0]  ncols_m1;
		logic [1:0]  nrows_m1;
		logic        last_img;
	} block_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

endpackage

// File: rtl/core/bcdec_pos.sv
// Configuration registers, size clamping and block position tracking.
// Depends on bcdec_pkg.
module bcdec_pos import bcdec_pkg::*; #(
	parameter int MAX_SIDE = 16384
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                advance,
	output blk_info_t           info
);

	localparam logic [16:0] MaxSideC = 17'(MAX_SIDE);

	logic        format_mode_q;
	logic [14:0] image_width_q;
	logic [14:0] image_height_q;
	logic [11:0] col_q;
	logic [11:0] row_q;

	logic [16:0] w17, h17, x0, y0, xrem, yrem;
	logic [14:0] bw, bh;
	logic        last_col, last_row, xin, yin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q  <= 1'b0;
			image_width_q  <= 15'd16;
			image_height_q <= 15'd16;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				CFG_FORMAT_MODE:  format_mode_q  <= cfg_data[0];
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		w17 = {2'b00, image_width_q};
		if (w17 == 17'd0) w17 = 17'd1;
		else if (w17 > MaxSideC) w17 = MaxSideC;
		h17 = {2'b00, image_height_q};
		if (h17 == 17'd0) h17 = 17'd1;
		else if (h17 > MaxSideC) h17 = MaxSideC;
	end

	assign bw = 15'((w17 + 17'd3) >> 2);
	assign bh = 15'((h17 + 17'd3) >> 2);
	assign last_col = (15'(col_q) + 15'd1) >= bw;
	assign last_row = (15'(row_q) + 15'd1) >= bh;

	assign x0   = {3'b000, col_q, 2'b00};
	assign y0   = {3'b000, row_q, 2'b00};
	assign xin  = x0 < w17;
	assign yin  = y0 < h17;
	assign xrem = w17 - x0;
	assign yrem = h17 - y0;

	always_comb begin
		info.bc3      = format_mode_q;
		info.col      = col_q;
		info.row      = row_q;
		info.ncols_m1 = (xrem >= 17'd4) ? 2'd3 : 2'(xrem[1:0] - 2'd1);
		info.nrows_m1 = (yrem >= 17'd4) ? 2'd3 : 2'(yrem[1:0] - 2'd1);
		info.nonempty = xin && yin;
		info.last_img = last_col && last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? 12'd0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + 12'd1;
			end
		end
	end

endmodule

// File: rtl/core/bcdec_texel.sv
// Decodes one texel of a held block: palette entry selection and interpolation.
// Depends on bcdec_pkg.
module bcdec_texel import bcdec_pkg::*; (
	input  block_t     blk,
	input  logic [3:0] idx,
	output rgba_t      texel
);

	logic [15:0] c0, c1;
	logic [31:0] cidx;
	logic [47:0] aidx;
	logic [1:0]  ci;
	logic [2:0]  ai;
	logic [7:0]  a0, a1;
	logic        four;
	logic [1:0]  cw0, cw1;
	cdiv_t       cdiv;
	logic [7:0]  apal;
	logic [3:0]  aw0, aw1;
	logic [10:0] asum;
	logic [22:0] aprod5, aprod7;

	function automatic logic [7:0] mix(input logic [7:0] ea, input logic [7:0] eb,
			input logic [1:0] wa, input logic [1:0] wb, input cdiv_t d);
		logic [9:0]  sum;
		logic [19:0] prod;
		logic [7:0]  r;
		sum  = 10'(wa) * 10'(ea) + 10'(wb) * 10'(eb);
		prod = 20'(sum) * 20'(RECIP3);
		case (d)
			DIV_ONE:   r = sum[7:0];
			DIV_TWO:   r = sum[8:1];
			DIV_THREE: r = prod[SHIFT3 +: 8];
			default:   r = sum[7:0];
		endcase
		return r;
	endfunction

	assign c0   = blk.color_word[15:0];
	assign c1   = blk.color_word[31:16];
	assign cidx = blk.color_word[63:32];
	assign aidx = blk.alpha_word[63:16];
	assign a0   = blk.alpha_word[7:0];
	assign a1   = blk.alpha_word[15:8];
	assign ci   = cidx[{idx, 1'b0} +: 2];
	assign ai   = aidx[({2'b00, idx} + {1'b0, idx, 1'b0}) +: 3];
	assign four = blk.bc3 || (c0 > c1);

	always_comb begin
		case (ci)
			2'd0: begin cw0 = 2'd1; cw1 = 2'd0; cdiv = DIV_ONE; end
			2'd1: begin cw0 = 2'd0; cw1 = 2'd1; cdiv = DIV_ONE; end
			2'd2: begin
				cw0 = four ? 2'd2 : 2'd1;
				cw1 = 2'd1;
				cdiv = four ? DIV_THREE : DIV_TWO;
			end
			default: begin
				cw0 = four ? 2'd1 : 2'd0;
				cw1 = four ? 2'd2 : 2'd0;
				cdiv = four ? DIV_THREE : DIV_ONE;
			end
		endcase
	end

	// Alpha weights: eight-level palette when a0 > a1, otherwise six levels plus 0 and 255.
	always_comb begin
		aw0 = 4'd8 - {1'b0, ai};
		aw1 = {1'b0, ai} - 4'd1;
		if (!(a0 > a1)) aw0 = 4'd6 - {1'b0, ai};
		asum   = 11'(aw0) * 11'(a0) + 11'(aw1) * 11'(a1);
		aprod5 = 23'(asum) * 23'(RECIP5);
		aprod7 = 23'(asum) * 23'(RECIP7);
		if (ai == 3'd0) apal = a0;
		else if (ai == 3'd1) apal = a1;
		else if (a0 > a1) apal = aprod7[SHIFT57 +: 8];
		else if (ai == 3'd6) apal = 8'd0;
		else if (ai == 3'd7) apal = 8'd255;
		else apal = aprod5[SHIFT57 +: 8];
	end

	always_comb begin
		texel.red   = mix({c0[15:11], 3'b000}, {c1[15:11], 3'b000}, cw0, cw1, cdiv);
		texel.green = mix({c0[10:5], 2'b00}, {c1[10:5], 2'b00}, cw0, cw1, cdiv);
		texel.blue  = mix({c0[4:0], 3'b000}, {c1[4:0], 3'b000}, cw0, cw1, cdiv);
		if (blk.bc3) texel.alpha = apal;
		else if (!four && ci == 2'd3) texel.alpha = 8'd0;
		else texel.alpha = 8'd255;
	end

endmodule

// File: rtl/core/bc1_bc3_texture_block_decoder.sv
// BC1/BC3 texture block decoder. An accepted block is registered in the holding stage,
// and each of its texels is then registered in the output stage. Each held block is
// stepped one texel position per cycle while the output is not stalled, up to its last
// texel inside the image; a block wholly outside the image is not held. The next block is
// taken in the cycle the last texel leaves the holding stage. Reset restores the
// configuration defaults, sets the block position to zero and empties both stages.
module bc1_bc3_texture_block_decoder import bcdec_pkg::*; #(
	parameter int MAX_SIDE = 16384
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [63:0]         alpha_word,
	input  logic [63:0]         color_word,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [13:0]         pixel_x,
	output logic [13:0]         pixel_y,
	output logic [7:0]          red,
	output logic [7:0]          green,
	output logic [7:0]          blue,
	output logic [7:0]          alpha,
	output logic                last_of_block,
	output logic                last_of_image
);

	blk_info_t info;
	block_t    blk_s1;
	logic      blk_valid_s1;
	logic [3:0] cnt_q;
	rgba_t     texel;

	logic       out_valid_q;
	logic [13:0] pixel_x_q, pixel_y_q;
	rgba_t      rgba_q;
	logic       last_of_block_q, last_of_image_q;

	logic out_free, step, texel_hit, at_last, blk_done, in_acc;

	bcdec_pos #(.MAX_SIDE(MAX_SIDE)) u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (in_acc),
		.info      (info)
	);

	bcdec_texel u_texel (
		.blk   (blk_s1),
		.idx   (cnt_q),
		.texel (texel)
	);

	assign out_free  = !out_valid_q || !out_stall;
	assign step      = blk_valid_s1 && out_free;
	assign texel_hit = (cnt_q[1:0] <= blk_s1.ncols_m1) && (cnt_q[3:2] <= blk_s1.nrows_m1);
	assign at_last   = cnt_q == {blk_s1.nrows_m1, blk_s1.ncols_m1};
	assign blk_done  = step && at_last;
	assign in_stall  = blk_valid_s1 && !blk_done;
	assign in_acc    = in_valid && !in_stall;

	// A block with no texel inside the image only moves the position on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blk_valid_s1 <= 1'b0;
			cnt_q        <= '0;
		end else if (in_acc && info.nonempty) begin
			blk_valid_s1 <= 1'b1;
			cnt_q        <= '0;
		end else begin
			if (blk_done) blk_valid_s1 <= 1'b0;
			if (step) cnt_q <= cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			blk_s1.alpha_word <= alpha_word;
			blk_s1.color_word <= color_word;
			blk_s1.bc3        <= info.bc3;
			blk_s1.col        <= info.col;
			blk_s1.row        <= info.row;
			blk_s1.ncols_m1   <= info.ncols_m1;
			blk_s1.nrows_m1   <= info.nrows_m1;
			blk_s1.last_img   <= info.last_img;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (out_free) out_valid_q <= step && texel_hit;
	end

	always_ff @(posedge clk) begin
		if (step) begin
			pixel_x_q       <= {blk_s1.col, cnt_q[1:0]};
			pixel_y_q       <= {blk_s1.row, cnt_q[3:2]};
			rgba_q          <= texel;
			last_of_block_q <= at_last;
			last_of_image_q <= at_last && blk_s1.last_img;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_x       = pixel_x_q;
	assign pixel_y       = pixel_y_q;
	assign red           = rgba_q.red;
	assign green         = rgba_q.green;
	assign blue          = rgba_q.blue;
	assign alpha         = rgba_q.alpha;
	assign last_of_block = last_of_block_q;
	assign last_of_image = last_of_image_q;

endmodule

// File: rtl/core/bcdec_checker.sv
// Port-level checker for the BC1/BC3 texture block decoder, with its bind statement.
// Depends on bcdec_pkg and the top level bc1_bc3_texture_block_decoder.
module bcdec_checker import bcdec_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                cfg_wr_en,
	input logic [CfgIdxW-1:0]  cfg_index,
	input logic [CfgDataW-1:0] cfg_data,
	input logic                in_valid,
	input logic                in_stall,
	input logic [63:0]         alpha_word,
	input logic [63:0]         color_word,
	input logic                out_valid,
	input logic                out_stall,
	input logic [13:0]         pixel_x,
	input logic [13:0]         pixel_y,
	input logic [7:0]          red,
	input logic [7:0]          green,
	input logic [7:0]          blue,
	input logic [7:0]          alpha,
	input logic                last_of_block,
	input logic                last_of_image
);

	logic        mid_q;
	logic [11:0] bx_q, by_q;
	logic [3:0]  pos_q;
	logic        out_acc;

	assign out_acc = out_valid && !out_stall;

	// Remembers the block of the last texel transaction while its block is still open.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= 1'b0;
			bx_q  <= '0;
			by_q  <= '0;
			pos_q <= '0;
		end else if (out_acc) begin
			mid_q <= !last_of_block;
			bx_q  <= pixel_x[13:2];
			by_q  <= pixel_y[13:2];
			pos_q <= {pixel_y[1:0], pixel_x[1:0]};
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_x) && $stable(pixel_y) && $stable(red)
			&& $stable(green) && $stable(blue) && $stable(alpha)
			&& $stable(last_of_block) && $stable(last_of_image))
		else $error("texel payload changed while stalled");

	a_image_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_image |-> last_of_block)
		else $error("last_of_image without last_of_block");

	a_block_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && mid_q |-> pixel_x[13:2] == bx_q && pixel_y[13:2] == by_q
			&& {pixel_y[1:0], pixel_x[1:0]} > pos_q)
		else $error("texel left its block or went out of row-major order");

endmodule

bind bc1_bc3_texture_block_decoder bcdec_checker u_bcdec_checker (.*);

// File: tb/bcdec_texel_checker.sv
// Scoreboard for the BC1/BC3 texture block decoder: mirrors the configuration writes,
// predicts the texels of every accepted block and compares each texel transaction in order.
// Depends on bcdec_pkg for the register index codes and the configuration port widths.
module bcdec_texel_checker import bcdec_pkg::*; #(
	parameter int MAX_SIDE = 16384
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [63:0]         alpha_word,
	input  logic [63:0]         color_word,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [13:0]         pixel_x,
	input  logic [13:0]         pixel_y,
	input  logic [7:0]          red,
	input  logic [7:0]          green,
	input  logic [7:0]          blue,
	input  logic [7:0]          alpha,
	input  logic                last_of_block,
	input  logic                last_of_image,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [13:0] x;
		logic [13:0] y;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  alpha;
		logic        last_blk;
		logic        last_img;
	} texel_t;

	texel_t      texel_queue[$];
	texel_t      want;
	logic        fmt_bc3;
	logic [14:0] image_width;
	logic [14:0] image_height;
	logic [11:0] block_col;
	logic [11:0] block_row;
	int          texel_seq;

	task automatic report_mismatch(input string msg);
		$display("%0t texel mismatch: %s", $time, msg);
		fail_count = fail_count + 1;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("texel %0d %s got %0h expected %0h",
				texel_seq, name, got, exp_val));
	endtask

	function automatic int unsigned clamp_side(input logic [14:0] v);
		if (v == 15'd0)
			return 1;
		if (int'(v) > MAX_SIDE)
			return MAX_SIDE;
		return 32'(v);
	endfunction

	// Expands the palettes of one block, emits its texels inside the image in row-major
	// order and steps the block position on.
	task automatic decode_block(input logic [63:0] aw, input logic [63:0] cw);
		texel_t      blk [16];
		logic [15:0] c;
		int unsigned side_w, side_h, blocks_w, blocks_h;
		int unsigned px, py, ci, av, a0, a1, n;
		int unsigned ep [2][3];
		int unsigned pal [4][3];
		int unsigned pal_a [4];
		int unsigned apal [8];
		bit          four_colour, end_col, end_row;

		side_w = clamp_side(image_width);
		side_h = clamp_side(image_height);
		blocks_w = (side_w + 3) / 4;
		blocks_h = (side_h + 3) / 4;
		end_col = int'(block_col) + 1 >= blocks_w;
		end_row = int'(block_row) + 1 >= blocks_h;
		four_colour = fmt_bc3 || (cw[15:0] > cw[31:16]);

		for (int e = 0; e < 2; e++) begin
			c = cw[16*e +: 16];
			ep[e][0] = 32'({c[15:11], 3'b000});
			ep[e][1] = 32'({c[10:5], 2'b00});
			ep[e][2] = 32'({c[4:0], 3'b000});
		end
		for (int k = 0; k < 3; k++) begin
			pal[0][k] = ep[0][k];
			pal[1][k] = ep[1][k];
			if (four_colour) begin
				pal[2][k] = (2 * ep[0][k] + ep[1][k]) / 3;
				pal[3][k] = (ep[0][k] + 2 * ep[1][k]) / 3;
			end else begin
				pal[2][k] = (ep[0][k] + ep[1][k]) / 2;
				pal[3][k] = 0;
			end
		end
		pal_a[0] = 255;
		pal_a[1] = 255;
		pal_a[2] = 255;
		pal_a[3] = four_colour ? 255 : 0;

		a0 = 32'(aw[7:0]);
		a1 = 32'(aw[15:8]);
		apal[0] = a0;
		apal[1] = a1;
		if (a0 > a1) begin
			for (int i = 2; i < 8; i++)
				apal[i] = ((8 - i) * a0 + (i - 1) * a1) / 7;
		end else begin
			for (int i = 2; i < 6; i++)
				apal[i] = ((6 - i) * a0 + (i - 1) * a1) / 5;
			apal[6] = 0;
			apal[7] = 255;
		end

		n = 0;
		for (int i = 0; i < 16; i++) begin
			px = int'(block_col) * 4 + (i % 4);
			py = int'(block_row) * 4 + (i / 4);
			if (px < side_w && py < side_h) begin
				ci = 32'(cw[32 + 2*i +: 2]);
				av = fmt_bc3 ? apal[aw[16 + 3*i +: 3]] : pal_a[ci];
				blk[n].x = px[13:0];
				blk[n].y = py[13:0];
				blk[n].red = pal[ci][0][7:0];
				blk[n].green = pal[ci][1][7:0];
				blk[n].blue = pal[ci][2][7:0];
				blk[n].alpha = av[7:0];
				blk[n].last_blk = 1'b0;
				blk[n].last_img = 1'b0;
				n++;
			end
		end
		// A block lying wholly outside a shrunken image yields no texel at all.
		if (n > 0) begin
			blk[n-1].last_blk = 1'b1;
			blk[n-1].last_img = end_col && end_row;
		end
		for (int i = 0; i < n; i++)
			texel_queue.push_back(blk[i]);

		if (end_col) begin
			block_col = '0;
			block_row = end_row ? 12'd0 : block_row + 12'd1;
		end else begin
			block_col = block_col + 12'd1;
		end
	endtask

	// Texel checks come first, then the block prediction, then the register mirror, so a
	// prediction always sees the configuration that was in force before this edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			texel_queue.delete();
			fmt_bc3 = 1'b0;
			image_width = 15'd16;
			image_height = 15'd16;
			block_col = '0;
			block_row = '0;
			texel_seq = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (texel_queue.size() == 0) begin
					report_mismatch($sformatf("texel %0d arrived with no block pending",
						texel_seq));
				end else begin
					want = texel_queue.pop_front();
					compare_field("pixel_x", 32'(pixel_x), 32'(want.x));
					compare_field("pixel_y", 32'(pixel_y), 32'(want.y));
					compare_field("red", 32'(red), 32'(want.red));
					compare_field("green", 32'(green), 32'(want.green));
					compare_field("blue", 32'(blue), 32'(want.blue));
					compare_field("alpha", 32'(alpha), 32'(want.alpha));
					compare_field("last_of_block", 32'(last_of_block), 32'(want.last_blk));
					compare_field("last_of_image", 32'(last_of_image), 32'(want.last_img));
				end
				texel_seq++;
			end
			if (in_valid && !in_stall)
				decode_block(alpha_word, color_word);
			if (cfg_wr_en) begin
				case (cfg_index)
					CFG_FORMAT_MODE:  fmt_bc3 = cfg_data[0];
					CFG_IMAGE_WIDTH:  image_width = cfg_data;
					CFG_IMAGE_HEIGHT: image_height = cfg_data;
					default: ;
				endcase
			end
			pending = texel_queue.size();
		end
	end

endmodule

// File: tb/tb_bc1_bc3_texture_block_decoder.sv
// Top of the BC1/BC3 texture block decoder testbench: clock, reset, configuration phases,
// block stimulus with random gaps, receiver stalls and the final verdict.
// Depends on bcdec_pkg, the decoder RTL and bcdec_texel_checker.
module tb_bc1_bc3_texture_block_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	import bcdec_pkg::*;

	localparam int MAX_SIDE       = 16384;
	localparam int RANDOM_ITEMS   = 330;
	localparam int HOLD_CYCLES    = 300;
	localparam int DRAIN_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PRESSURE_PHASE = 2;
	localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                in_valid;
	logic                in_stall;
	logic [63:0]         alpha_word;
	logic [63:0]         color_word;
	logic                out_valid;
	logic                out_stall;
	logic [13:0]         pixel_x;
	logic [13:0]         pixel_y;
	logic [7:0]          red;
	logic [7:0]          green;
	logic [7:0]          blue;
	logic [7:0]          alpha;
	logic                last_of_block;
	logic                last_of_image;
	int                  fail_count;
	int                  pending_texels;

	bit                  hold_pending = 1'b0;
	int                  no_gap_left = 0;

	bc1_bc3_texture_block_decoder #(
		.MAX_SIDE(MAX_SIDE)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.alpha_word(alpha_word),
		.color_word(color_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.last_of_block(last_of_block),
		.last_of_image(last_of_image)
	);

	bcdec_texel_checker #(
		.MAX_SIDE(MAX_SIDE)
	) u_texel_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.alpha_word(alpha_word),
		.color_word(color_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.last_of_block(last_of_block),
		.last_of_image(last_of_image),
		.fail_count(fail_count),
		.pending(pending_texels)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Ends the run when no transaction of any kind has happened for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("bc1_bc3_texture_block_decoder regression: fail");
		$finish;
	end

	// Receiver: segments of free flow, random stalls and a few long stalls. A hold request
	// from the stimulus stalls the output long enough for the decoder to back up.
	initial begin : sink
		int seg_left;
		int seg_kind;
		seg_left = 0;
		seg_kind = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (seg_left == 0) begin
				seg_kind = $urandom_range(0, 9);
				seg_left = (seg_kind == 9) ? $urandom_range(10, 60) : $urandom_range(4, 40);
			end
			seg_left--;
			if (seg_kind < 4)
				out_stall <= 1'b0;
			else if (seg_kind < 9)
				out_stall <= ($urandom_range(0, 2) == 0);
			else
				out_stall <= 1'b1;
		end
	end

	function automatic int pick_gap();
		int r;
		if (no_gap_left > 0) begin
			no_gap_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			no_gap_left = $urandom_range(10, 30);
			return 0;
		end
		if (r < 45)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [14:0] pick_side();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 15'($urandom_range(1, 24));
		if (r < 68)
			return 15'd0;
		if (r < 80)
			return 15'($urandom_range(25, 64));
		if (r < 90)
			return r[0] ? 15'd16384 : 15'd32767;
		return 15'($urandom_range(0, 32767));
	endfunction

	task automatic random_block(output logic [63:0] aw, output logic [63:0] cw);
		aw = {$urandom, $urandom};
		cw = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: cw[31:16] = cw[15:0];
			1: aw[15:8] = aw[7:0];
			2: begin
				cw[15:0] = 16'hFFFF;
				aw[7:0] = 8'h00;
			end
			3: begin
				cw[31:16] = 16'h0000;
				aw[15:8] = 8'hFF;
			end
			default: ;
		endcase
	endtask

	// Called at a falling edge; returns at the falling edge after the block transaction.
	task automatic send_block(input logic [63:0] aw, input logic [63:0] cw);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		alpha_word <= aw;
		color_word <= cw;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	// Registers change only with the decoder drained; the extra cycles cover a block that
	// lies outside the image and so leaves no texel to wait for.
	task automatic configure(input logic bc3, input logic [14:0] w, input logic [14:0] h);
		logic [CfgDataW-1:0] mode_val;
		in_valid <= 1'b0;
		while (pending_texels != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		mode_val = 15'($urandom_range(0, 32767));
		mode_val[0] = bc3;
		write_reg(CFG_FORMAT_MODE, mode_val);
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_UNUSED, 15'($urandom_range(0, 32767)));
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		logic [63:0] aw;
		logic [63:0] cw;
		int          count;
		int          phase;
		int          random_sent;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		alpha_word = '0;
		color_word = '0;
		phase = 0;
		random_sent = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// BC1 on a 2x2-block image, run past its end so the position wraps. Covers both
		// colour modes, equal endpoints and the transparent black entry.
		configure(1'b0, 15'd8, 15'd8);
		send_block(64'h0, 64'h0);
		send_block({$urandom, $urandom}, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
		send_block({$urandom, $urandom}, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
		send_block({$urandom, $urandom}, {32'hE4E4E4E4, 16'hF81F, 16'hF81F});
		send_block({$urandom, $urandom}, {32'h1B1B1B1B, 16'h07E0, 16'h8410});
		send_block(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);

		// BC3 on a cropped image: both alpha palettes, equal and extreme endpoints, and an
		// index word with its top bit set.
		configure(1'b1, 15'd5, 15'd6);
		send_block({48'hFAC688FAC688, 8'h10, 8'hF0}, {32'hE4E4E4E4, 16'h0000, 16'hFFFF});
		send_block({48'hFAC688FAC688, 8'hF0, 8'h10}, {32'hE4E4E4E4, 16'hFFFF, 16'h0000});
		send_block({48'hFAC688FAC688, 8'h80, 8'h80}, {32'h1B1B1B1B, 16'h1234, 16'h1234});
		send_block({48'hFFFFFFFFFFFF, 8'h00, 8'hFF}, {$urandom, $urandom});
		send_block({48'h000000000000, 8'hFF, 8'h00}, {$urandom, $urandom});
		send_block({$urandom, $urandom}, {$urandom, $urandom});

		// Zero sizes are taken as one pixel: every block is a whole image.
		configure(1'b0, 15'd0, 15'd0);
		repeat (3) begin
			random_block(aw, cw);
			send_block(aw, cw);
		end

		// Move the position into the image, then shrink the image beneath it.
		configure(1'b1, 15'd16, 15'd16);
		repeat (5) begin
			random_block(aw, cw);
			send_block(aw, cw);
		end
		configure(1'b1, 15'd4, 15'd4);
		repeat (3) begin
			random_block(aw, cw);
			send_block(aw, cw);
		end

		// Sizes beyond the largest side are clamped.
		configure(1'b0, 15'd32767, 15'd16384);
		repeat (3) begin
			random_block(aw, cw);
			send_block(aw, cw);
		end

		while (random_sent < RANDOM_ITEMS) begin
			if (phase == PRESSURE_PHASE) begin
				configure(1'b1, 15'd16, 15'd16);
				hold_pending = 1'b1;
				no_gap_left = 20;
			end else begin
				configure(1'($urandom_range(0, 1)), pick_side(), pick_side());
			end
			count = $urandom_range(15, 40);
			repeat (count) begin
				random_block(aw, cw);
				send_block(aw, cw);
			end
			random_sent += count;
			phase++;
		end

		in_valid <= 1'b0;
		while (pending_texels != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_texels == 0)
			$display("bc1_bc3_texture_block_decoder regression: pass");
		else
			$display("bc1_bc3_texture_block_decoder regression: fail");
		$finish;
	end

endmodule
